// ===== design/dpq_pkg.sv =====
`default_nettype none
package dpq_pkg;

	localparam int CMD_W       = 3;
	localparam int FILL_W      = 6;
	localparam int TMO_W       = 16;
	localparam int PORT_TIME_W = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;

	// Largest capacity the capacity register can express.
	localparam int CAP_MAX = (1 << FILL_W) - 1;

	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int TIME_BITS_DEF   = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_TMO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_TMO = 2'd2;

	localparam logic [FILL_W-1:0] CAP_RESET        = 6'd30;
	localparam logic [TMO_W-1:0]  HIGH_TMO_RESET   = 16'd2000;
	localparam logic [TMO_W-1:0]  NORMAL_TMO_RESET = 16'd5000;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ_HIGH    = 3'd0,
		CMD_ENQ_NORMAL  = 3'd1,
		CMD_EXPIRE      = 3'd2,
		CMD_SEND_HIGH   = 3'd3,
		CMD_SEND_NORMAL = 3'd4,
		CMD_DROP_NORMAL = 3'd5,
		CMD_DROP_HIGH   = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_XP_EVAL,
		S_XP_WAIT,
		S_SETTLE,
		S_AGE_H,
		S_AGE_N
	} state_t;

endpackage
`default_nettype wire

// ===== design/dpq_stamp_ram.sv =====
`default_nettype none
module dpq_stamp_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== design/dpq_age_unit.sv =====
`default_nettype none
module dpq_age_unit
	import dpq_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic [TIME_BITS-1:0] now,
	input  wire logic [TIME_BITS-1:0] stamp,
	input  wire logic [TMO_W-1:0]     limit,
	output logic      [TIME_BITS-1:0] age,
	output logic                      over
);

	// The subtraction wraps at the time width, so a stamp taken before a
	// counter rollover still gives the right age.
	assign age  = now - stamp;
	assign over = age > TIME_BITS'(limit);

endmodule
`default_nettype wire

// ===== design/dual_priority_queue_timeout_drop_core.sv =====
`default_nettype none
// Two timestamped FIFOs, high and normal priority, driven by one command per request.
// Each request is accepted only in the idle state and answered with exactly one
// result. Enqueue, send, drop and the unused code step through execute, settle and
// the high and normal age steps; an expire replaces settle with head evaluation and a
// wait step after each entry removed. The single subtract-and-compare age unit
// evaluates one head per step, and the registered read port of each stamp memory must
// be read anew after every pop before the new head can be examined. A finished result
// waits in the output register while the next request is taken. The stamp memories
// are not cleared after reset; only entries written by an enqueue are ever read. The
// configuration registers are to be written only while the block is idle.
module dual_priority_queue_timeout_drop_core
	import dpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [CMD_W-1:0]       cmd,
	input  wire logic [PORT_TIME_W-1:0] now_ms,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        done_res,
	output logic      [PORT_TIME_W-1:0] waited_ms,
	output logic      [FILL_W-1:0]      high_expired,
	output logic      [FILL_W-1:0]      normal_expired,
	output logic      [FILL_W-1:0]      high_count,
	output logic      [FILL_W-1:0]      normal_count,
	output logic      [PORT_TIME_W-1:0] high_age_ms,
	output logic      [PORT_TIME_W-1:0] normal_age_ms,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data
);

	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int SUM_W     = ((PTR_W > FILL_W) ? PTR_W : FILL_W) + 1;
	localparam int DEPTH_LIM = (QUEUE_DEPTH < CAP_MAX) ? QUEUE_DEPTH : CAP_MAX;
	localparam logic [FILL_W-1:0] DEPTH_LIM_F = FILL_W'(DEPTH_LIM);

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	// The entry written is always below the depth, so one subtract wraps the sum.
	function automatic logic [PTR_W-1:0] tail_addr(input logic [PTR_W-1:0] h,
			input logic [FILL_W-1:0] f);
		logic [SUM_W-1:0] s;
		s = SUM_W'(h) + SUM_W'(f);
		if (s >= SUM_W'(QUEUE_DEPTH)) begin
			s = s - SUM_W'(QUEUE_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	// Configuration registers.
	logic [FILL_W-1:0] cap_q;
	logic [TMO_W-1:0]  high_tmo_q;
	logic [TMO_W-1:0]  normal_tmo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAP_RESET;
			high_tmo_q   <= HIGH_TMO_RESET;
			normal_tmo_q <= NORMAL_TMO_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAPACITY:   cap_q        <= cfg_data[FILL_W-1:0];
				REG_HIGH_TMO:   high_tmo_q   <= cfg_data[TMO_W-1:0];
				REG_NORMAL_TMO: normal_tmo_q <= cfg_data[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and queue state.
	state_t                state_q, state_d;
	cmd_t                  cmd_q, cmd_d;
	logic [TIME_BITS-1:0]  now_q, now_d;
	logic [PTR_W-1:0]      head_h_q, head_h_d, head_n_q, head_n_d;
	logic [FILL_W-1:0]     fill_h_q, fill_h_d, fill_n_q, fill_n_d;
	logic                  done_q, done_d;
	logic [TIME_BITS-1:0]  waited_q, waited_d;
	logic [FILL_W-1:0]     hx_q, hx_d, nx_q, nx_d;
	logic                  xp_high_q, xp_high_d;
	logic [TIME_BITS-1:0]  hage_q, hage_d;

	logic                  we_h, we_n;
	logic                  unit_high;
	logic                  load;
	logic [TIME_BITS-1:0]  rd_h, rd_n;
	logic [TIME_BITS-1:0]  unit_stamp, unit_age;
	logic [TMO_W-1:0]      unit_limit;
	logic                  unit_over;
	logic                  out_valid_q;

	dpq_stamp_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(TIME_BITS)) u_high_ram (
		.clk   (clk),
		.we    (we_h),
		.waddr (tail_addr(head_h_q, fill_h_q)),
		.wdata (now_q),
		.raddr (head_h_q),
		.rdata (rd_h)
	);

	dpq_stamp_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(TIME_BITS)) u_normal_ram (
		.clk   (clk),
		.we    (we_n),
		.waddr (tail_addr(head_n_q, fill_n_q)),
		.wdata (now_q),
		.raddr (head_n_q),
		.rdata (rd_n)
	);

	assign unit_stamp = unit_high ? rd_h : rd_n;
	assign unit_limit = unit_high ? high_tmo_q : normal_tmo_q;

	dpq_age_unit #(.TIME_BITS(TIME_BITS)) u_age (
		.now   (now_q),
		.stamp (unit_stamp),
		.limit (unit_limit),
		.age   (unit_age),
		.over  (unit_over)
	);

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		now_d     = now_q;
		head_h_d  = head_h_q;
		head_n_d  = head_n_q;
		fill_h_d  = fill_h_q;
		fill_n_d  = fill_n_q;
		done_d    = done_q;
		waited_d  = waited_q;
		hx_d      = hx_q;
		nx_d      = nx_q;
		xp_high_d = xp_high_q;
		hage_d    = hage_q;
		we_h      = 1'b0;
		we_n      = 1'b0;
		unit_high = 1'b1;
		load      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_d    = cmd_t'(cmd);
					now_d    = TIME_BITS'(now_ms);
					done_d   = 1'b0;
					waited_d = '0;
					hx_d     = '0;
					nx_d     = '0;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_SETTLE;
				case (cmd_q)
					CMD_ENQ_HIGH: begin
						if (fill_h_q < cap_q && fill_h_q < DEPTH_LIM_F) begin
							we_h     = 1'b1;
							fill_h_d = fill_h_q + 1'b1;
							done_d   = 1'b1;
						end
					end
					CMD_ENQ_NORMAL: begin
						if (fill_n_q < cap_q && fill_n_q < DEPTH_LIM_F) begin
							we_n     = 1'b1;
							fill_n_d = fill_n_q + 1'b1;
							done_d   = 1'b1;
						end
					end
					CMD_EXPIRE: begin
						xp_high_d = 1'b1;
						state_d   = S_XP_EVAL;
					end
					CMD_SEND_HIGH: begin
						unit_high = 1'b1;
						if (fill_h_q != '0) begin
							waited_d = unit_age;
							head_h_d = ptr_next(head_h_q);
							fill_h_d = fill_h_q - 1'b1;
							done_d   = 1'b1;
						end
					end
					CMD_SEND_NORMAL: begin
						unit_high = 1'b0;
						if (fill_n_q != '0) begin
							waited_d = unit_age;
							head_n_d = ptr_next(head_n_q);
							fill_n_d = fill_n_q - 1'b1;
							done_d   = 1'b1;
						end
					end
					CMD_DROP_HIGH: begin
						if (fill_h_q != '0) begin
							head_h_d = ptr_next(head_h_q);
							fill_h_d = fill_h_q - 1'b1;
							done_d   = 1'b1;
						end
					end
					CMD_DROP_NORMAL: begin
						if (fill_n_q != '0) begin
							head_n_d = ptr_next(head_n_q);
							fill_n_d = fill_n_q - 1'b1;
							done_d   = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_XP_EVAL: begin
				// The high queue is drained first, then the normal queue.
				unit_high = xp_high_q;
				if (xp_high_q) begin
					if (fill_h_q != '0 && unit_over) begin
						head_h_d = ptr_next(head_h_q);
						fill_h_d = fill_h_q - 1'b1;
						hx_d     = hx_q + 1'b1;
						done_d   = 1'b1;
						state_d  = S_XP_WAIT;
					end else begin
						xp_high_d = 1'b0;
					end
				end else begin
					if (fill_n_q != '0 && unit_over) begin
						head_n_d = ptr_next(head_n_q);
						fill_n_d = fill_n_q - 1'b1;
						nx_d     = nx_q + 1'b1;
						done_d   = 1'b1;
						state_d  = S_XP_WAIT;
					end else begin
						state_d = S_AGE_H;
					end
				end
			end
			S_XP_WAIT: begin
				state_d = S_XP_EVAL;
			end
			S_SETTLE: begin
				state_d = S_AGE_H;
			end
			S_AGE_H: begin
				unit_high = 1'b1;
				hage_d    = (fill_h_q != '0) ? unit_age : '0;
				state_d   = S_AGE_N;
			end
			S_AGE_N: begin
				unit_high = 1'b0;
				if (!out_valid_q || !out_stall) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_h_q  <= '0;
			head_n_q  <= '0;
			fill_h_q  <= '0;
			fill_n_q  <= '0;
			xp_high_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_h_q  <= head_h_d;
			head_n_q  <= head_n_d;
			fill_h_q  <= fill_h_d;
			fill_n_q  <= fill_n_d;
			xp_high_q <= xp_high_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		now_q    <= now_d;
		done_q   <= done_d;
		waited_q <= waited_d;
		hx_q     <= hx_d;
		nx_q     <= nx_d;
		hage_q   <= hage_d;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			done_res       <= done_q;
			waited_ms      <= PORT_TIME_W'(waited_q);
			high_expired   <= hx_q;
			normal_expired <= nx_q;
			high_count     <= fill_h_q;
			normal_count   <= fill_n_q;
			high_age_ms    <= PORT_TIME_W'(hage_q);
			normal_age_ms  <= PORT_TIME_W'((fill_n_q != '0) ? unit_age : '0);
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_h_q <= DEPTH_LIM_F && fill_n_q <= DEPTH_LIM_F)
		else $error("queue occupancy beyond its limit");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> $stable(fill_h_q) && $stable(fill_n_q))
		else $error("occupancy changed while idle");

	a_exec_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |=> (fill_h_q == $past(fill_h_q) ||
			fill_h_q == FILL_W'($past(fill_h_q) + 1'b1) ||
			fill_h_q == FILL_W'($past(fill_h_q) - 1'b1)))
		else $error("high occupancy moved by more than one entry");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_AGE_N)
		else $error("result presented outside the final step");
`endif

endmodule
`default_nettype wire
